>>> rtl/idw_heat_map_pixel_unit_macros.svh
// ----------------------------------------------------------------------------
// idw heat map assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef IDW_HEAT_MAP_PIXEL_UNIT_MACROS_SVH
`define IDW_HEAT_MAP_PIXEL_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define IDW_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/idw_hm_pkg.sv
// ----------------------------------------------------------------------------
// idw heat map package
// sizes, item types and the sensor position rom
// ----------------------------------------------------------------------------
package idw_hm_pkg;

    localparam int NUM_SENSORS = 54;
    localparam int GRID_DIM    = 200;
    localparam int GRID_HALF   = GRID_DIM / 2;

    localparam int ROM_SIZE = 54;
    localparam int ROM_W    = 6;
    localparam int POS_MAX  = 20692;

    localparam int CNT_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 16;
    localparam int COORD_W = 8;
    localparam int PIX_W   = 8;
    localparam int PIX_MAX = 255;

    // largest distance component in q.8
    localparam int HALF_SPAN = (GRID_HALF > (255 - GRID_HALF)) ? GRID_HALF : (255 - GRID_HALF);
    localparam int AX_MAX    = HALF_SPAN * 256 + POS_MAX;
    localparam int AX_W      = $clog2(AX_MAX + 1);
    localparam int DX_W      = AX_W + 1;
    localparam int D2_W      = 2 * AX_W + 1;

    // square root pipeline
    localparam int SQ_STEPS = (D2_W + 1) / 2;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int REM_W    = SQ_STEPS + 3;
    localparam int D_W      = SQ_STEPS;

    // reciprocal pipeline, weight is q8.24
    localparam int W_W       = 32;
    localparam int DIV_STEPS = W_W;
    localparam int DR_W      = D_W + 1;

    // accumulators
    localparam int TOT_W = W_W + CNT_W;
    localparam int SUM_W = TOT_W + VAL_W;

    // final scaling, round(255 / (2 pi) * 2^16)
    localparam int SCL_W                = 22;
    localparam logic [SCL_W-1:0] SCALE_Q16 = SCL_W'(2659746);
    localparam int MEAN_DIV_STEPS       = VAL_W;
    localparam int MCNT_W               = $clog2(MEAN_DIV_STEPS);

    localparam logic signed [15:0] POS_X [ROM_SIZE] = '{
        -16'sd7843, -16'sd5273, -16'sd2703, -16'sd1330, 16'sd1330, 16'sd2703, 16'sd5273,
        16'sd7843,
        -16'sd12850, -16'sd10280, 16'sd10280, 16'sd12850,
        -16'sd12983, 16'sd12983, -16'sd15419, 16'sd15419, -16'sd15552, 16'sd15552,
        -16'sd17989, 16'sd17989,
        -16'sd18122, 16'sd18122, -16'sd20559, 16'sd20559, -16'sd20692, 16'sd20692,
        -16'sd20559, 16'sd20559,
        -16'sd20692, 16'sd20692, -16'sd20559, 16'sd20559, -16'sd18122, 16'sd18122,
        -16'sd17989, 16'sd17989,
        -16'sd15552, 16'sd15552, -16'sd15419, 16'sd15419, -16'sd12983, 16'sd12983,
        -16'sd12850, -16'sd10280, 16'sd10280, 16'sd12850,
        -16'sd7843, -16'sd5273, -16'sd2703, -16'sd1330, 16'sd1330, 16'sd2703, 16'sd5273,
        16'sd7843
    };

    localparam logic signed [15:0] POS_Y [ROM_SIZE] = '{
        -16'sd20505, -16'sd20505, -16'sd20505, -16'sd20505, -16'sd20505, -16'sd20505,
        -16'sd20505, -16'sd20505,
        -16'sd17970, -16'sd17970, -16'sd17970, -16'sd17970,
        -16'sd15436, -16'sd15436, -16'sd12902, -16'sd12902, -16'sd10367, -16'sd10367,
        -16'sd7833, -16'sd7833,
        -16'sd5299, -16'sd5299, -16'sd2765, -16'sd2765, -16'sd2303, -16'sd2303, 16'sd0,
        16'sd0,
        16'sd2303, 16'sd2303, 16'sd2765, 16'sd2765, 16'sd5299, 16'sd5299, 16'sd7833,
        16'sd7833,
        16'sd10367, 16'sd10367, 16'sd12902, 16'sd12902, 16'sd15436, 16'sd15436,
        16'sd17970, 16'sd17970, 16'sd17970, 16'sd17970,
        16'sd20505, 16'sd20505, 16'sd20505, 16'sd20505, 16'sd20505, 16'sd20505,
        16'sd20505, 16'sd20505
    };

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic [IDX_W-1:0]   sensor_index;
        logic [VAL_W-1:0]   sensor_value;
        logic [COORD_W-1:0] grid_row;
        logic [COORD_W-1:0] grid_col;
    } in_item_t;

    typedef struct packed
    {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
    } out_item_t;

    // tag that travels with one sensor term through the pipeline
    typedef struct packed
    {
        logic             valid;
        logic             last;
        logic [CNT_W-1:0] idx;
    } wtag_t;

endpackage

>>> rtl/idw_hm_in_if.sv
// ----------------------------------------------------------------------------
// idw heat map request channel
// valid/ready channel carrying load and pixel requests
// ----------------------------------------------------------------------------
interface idw_hm_in_if
    import idw_hm_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/idw_hm_out_if.sv
// ----------------------------------------------------------------------------
// idw heat map result channel
// valid/ready channel carrying computed pixels
// ----------------------------------------------------------------------------
interface idw_hm_out_if
    import idw_hm_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/idw_hm_weight.sv
// ----------------------------------------------------------------------------
// idw heat map weight pipeline
// squares, square root and reciprocal, one sensor term per cycle
// ----------------------------------------------------------------------------
module idw_hm_weight
    import idw_hm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  wtag_t           in_tag,
    input  logic [AX_W-1:0] ax,
    input  logic [AX_W-1:0] ay,
    output wtag_t           out_tag,
    output logic [W_W-1:0]  weight
);

    wtag_t                mul_tag_reg;
    logic [2*AX_W-1:0]    axx_reg;
    logic [2*AX_W-1:0]    ayy_reg;

    wtag_t                sq_tag_reg  [SQ_STEPS+1];
    logic [RAD_W-1:0]     sq_rad_reg  [SQ_STEPS+1];
    logic [REM_W-1:0]     sq_rem_reg  [SQ_STEPS+1];
    logic [D_W-1:0]       sq_root_reg [SQ_STEPS+1];

    logic [RAD_W-1:0]     sq_rad_next  [SQ_STEPS];
    logic [REM_W-1:0]     sq_rem_next  [SQ_STEPS];
    logic [D_W-1:0]       sq_root_next [SQ_STEPS];
    logic [REM_W-1:0]     sq_t         [SQ_STEPS];
    logic [REM_W-1:0]     sq_trial     [SQ_STEPS];

    wtag_t                dv_tag_reg [DIV_STEPS+1];
    logic [D_W-1:0]       dv_d_reg   [DIV_STEPS+1];
    logic [DR_W-1:0]      dv_rem_reg [DIV_STEPS+1];
    logic [W_W-1:0]       dv_q_reg   [DIV_STEPS+1];
    logic                 dv_sat_reg [DIV_STEPS+1];

    logic [DR_W-1:0]      dv_rem_next [DIV_STEPS];
    logic [W_W-1:0]       dv_q_next   [DIV_STEPS];
    logic [DR_W-1:0]      dv_t        [DIV_STEPS];

    wtag_t                w_tag_reg;
    logic [W_W-1:0]       w_reg;

    logic [D2_W-1:0]      d2;

    assign d2 = D2_W'(axx_reg) + D2_W'(ayy_reg);

    // one root bit per stage
    always_comb
    begin
        for (int s = 0; s < SQ_STEPS; s++)
        begin
            sq_t[s]     = {sq_rem_reg[s][REM_W-3:0], sq_rad_reg[s][RAD_W-1 -: 2]};
            sq_trial[s] = REM_W'({sq_root_reg[s], 2'b01});
            sq_rad_next[s] = {sq_rad_reg[s][RAD_W-3:0], 2'b00};
            if (sq_t[s] >= sq_trial[s])
            begin
                sq_rem_next[s]  = sq_t[s] - sq_trial[s];
                sq_root_next[s] = {sq_root_reg[s][D_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[s]  = sq_t[s];
                sq_root_next[s] = {sq_root_reg[s][D_W-2:0], 1'b0};
            end
        end
    end

    // one quotient bit of 2^32 / d per stage
    always_comb
    begin
        for (int b = 0; b < DIV_STEPS; b++)
        begin
            dv_t[b] = {dv_rem_reg[b][D_W-1:0], 1'b0};
            if (dv_t[b] >= {1'b0, dv_d_reg[b]})
            begin
                dv_rem_next[b] = dv_t[b] - {1'b0, dv_d_reg[b]};
                dv_q_next[b]   = {dv_q_reg[b][W_W-2:0], 1'b1};
            end
            else
            begin
                dv_rem_next[b] = dv_t[b];
                dv_q_next[b]   = {dv_q_reg[b][W_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_tag_reg <= '0;
            w_tag_reg   <= '0;
            for (int s = 0; s <= SQ_STEPS; s++)
            begin
                sq_tag_reg[s] <= '0;
            end
            for (int b = 0; b <= DIV_STEPS; b++)
            begin
                dv_tag_reg[b] <= '0;
            end
        end
        else
        begin
            mul_tag_reg   <= in_tag;
            sq_tag_reg[0] <= mul_tag_reg;
            for (int s = 0; s < SQ_STEPS; s++)
            begin
                sq_tag_reg[s+1] <= sq_tag_reg[s];
            end
            dv_tag_reg[0] <= sq_tag_reg[SQ_STEPS];
            for (int b = 0; b < DIV_STEPS; b++)
            begin
                dv_tag_reg[b+1] <= dv_tag_reg[b];
            end
            w_tag_reg <= dv_tag_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        axx_reg <= ax * ax;
        ayy_reg <= ay * ay;

        sq_rad_reg[0]  <= RAD_W'(d2);
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        for (int s = 0; s < SQ_STEPS; s++)
        begin
            sq_rad_reg[s+1]  <= sq_rad_next[s];
            sq_rem_reg[s+1]  <= sq_rem_next[s];
            sq_root_reg[s+1] <= sq_root_next[s];
        end

        // distance of zero or one saturates the weight
        dv_d_reg[0]   <= sq_root_reg[SQ_STEPS];
        dv_rem_reg[0] <= DR_W'(1);
        dv_q_reg[0]   <= '0;
        dv_sat_reg[0] <= (sq_root_reg[SQ_STEPS] < D_W'(2));
        for (int b = 0; b < DIV_STEPS; b++)
        begin
            dv_d_reg[b+1]   <= dv_d_reg[b];
            dv_rem_reg[b+1] <= dv_rem_next[b];
            dv_q_reg[b+1]   <= dv_q_next[b];
            dv_sat_reg[b+1] <= dv_sat_reg[b];
        end

        w_reg <= dv_sat_reg[DIV_STEPS] ? '1 : dv_q_reg[DIV_STEPS];
    end

    assign out_tag = w_tag_reg;
    assign weight  = w_reg;

endmodule

>>> rtl/idw_heat_map_pixel_unit.sv
// ----------------------------------------------------------------------------
// idw heat map pixel unit
// inverse distance weighted grey level for one grid point per request
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                           transfer
//  -------  ---  ------------------------------------------------  ----------------
//  req      in   cmd, sensor_index, sensor_value, grid_row/col     valid & ready
//  rsp      out  pixel, out_row, out_col                           valid & ready
//
//  a load gives no result
//  for a pixel, one sensor term enters the weight pipeline per cycle, the root and
//  reciprocal pipelines set the depth, and the final mean division runs one
//  quotient bit per cycle
//  the result sits in an output register, so the next request is taken while it waits
//  reset clears control only; sensor values are undefined until loaded
//
module idw_heat_map_pixel_unit
    import idw_hm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    idw_hm_in_if.sink    req,
    idw_hm_out_if.source rsp
);

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // sensor value store; writes only while idle and reads only while running,
    // so no same-entry overlap needs forwarding
    logic [VAL_W-1:0]   sv_mem [NUM_SENSORS];
    logic [VAL_W-1:0]   sv_rd_reg;

    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;

    // issue counters
    logic               issue_act_reg, issue_act_next;
    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic [ROM_W-1:0]   rom_cnt_reg, rom_cnt_next;

    // distance stage
    wtag_t              dist_tag_reg;
    logic [AX_W-1:0]    ax_reg;
    logic [AX_W-1:0]    ay_reg;

    // weight pipeline outputs
    wtag_t              w_tag;
    logic [W_W-1:0]     weight;

    // value aligned with weight after the memory read
    wtag_t              rd_tag_reg;
    logic [W_W-1:0]     rd_w_reg;

    // product stage
    wtag_t              prod_tag_reg;
    logic [VAL_W+W_W-1:0] prod_reg;
    logic [W_W-1:0]     prod_w_reg;

    // accumulators
    logic [SUM_W-1:0]   sum_reg;
    logic [TOT_W-1:0]   tot_reg;
    logic               acc_done_reg;

    // mean division
    logic [TOT_W-1:0]   qrem_reg;
    logic [VAL_W-1:0]   qlow_reg;
    logic [MCNT_W-1:0]  mcnt_reg;
    logic [TOT_W:0]     q_t;
    logic               q_ge;

    // scaling and output
    logic [VAL_W+SCL_W-1:0] scl_reg;
    logic [VAL_W+SCL_W-25:0] scl_top;
    logic [PIX_W-1:0]   scl_sat;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg;
    logic               out_load;

    logic               req_xfer;
    logic               pix_xfer;
    logic               load_xfer;
    logic               issue_last;

    // grid centre offset and distance components
    logic [DX_W-1:0]        row_off;
    logic [DX_W-1:0]        col_off;
    logic signed [DX_W-1:0] cx;
    logic signed [DX_W-1:0] cy;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic [DX_W-1:0]        dx_abs;
    logic [DX_W-1:0]        dy_abs;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign pix_xfer  = req_xfer && (req.data.cmd == CMD_PIXEL);
    assign load_xfer = req_xfer && (req.data.cmd == CMD_LOAD);

    assign issue_last = (issue_cnt_reg == CNT_W'(NUM_SENSORS - 1));

    // (row - GRID_DIM/2) * 256 in q.8
    assign row_off = DX_W'(row_reg) - DX_W'(GRID_HALF);
    assign col_off = DX_W'(col_reg) - DX_W'(GRID_HALF);
    assign cx      = signed'({row_off[DX_W-9:0], 8'd0});
    assign cy      = signed'({col_off[DX_W-9:0], 8'd0});
    assign dx      = cx - DX_W'(POS_X[rom_cnt_reg]);
    assign dy      = cy - DX_W'(POS_Y[rom_cnt_reg]);
    assign dx_abs  = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
    assign dy_abs  = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);

    // restoring step of sum / tot, quotient known to fit VAL_W bits
    assign q_t  = {qrem_reg, qlow_reg[VAL_W-1]};
    assign q_ge = (q_t >= {1'b0, tot_reg});

    // mean * 255/(2 pi) in q8.8 -> integer, saturated
    assign scl_top = scl_reg[VAL_W+SCL_W-1:24];
    assign scl_sat = (scl_top > (VAL_W+SCL_W-24)'(PIX_MAX)) ? PIX_W'(PIX_MAX)
                                                            : PIX_W'(scl_top);

    assign out_load = (state_reg == ST_HOLD) && (!out_valid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        issue_act_next = issue_act_reg;
        issue_cnt_next = issue_cnt_reg;
        rom_cnt_next   = rom_cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_xfer)
                begin
                    state_next     = ST_RUN;
                    issue_act_next = 1'b1;
                    issue_cnt_next = '0;
                    rom_cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (issue_act_reg)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    rom_cnt_next   = (rom_cnt_reg == ROM_W'(ROM_SIZE - 1)) ? '0
                                                                           : rom_cnt_reg + ROM_W'(1);
                    if (issue_last)
                    begin
                        issue_act_next = 1'b0;
                    end
                end
                if (acc_done_reg)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (mcnt_reg == MCNT_W'(MEAN_DIV_STEPS - 1))
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_act_reg <= 1'b0;
            issue_cnt_reg <= '0;
            rom_cnt_reg   <= '0;
            dist_tag_reg  <= '0;
            rd_tag_reg    <= '0;
            prod_tag_reg  <= '0;
            acc_done_reg  <= 1'b0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_act_reg <= issue_act_next;
            issue_cnt_reg <= issue_cnt_next;
            rom_cnt_reg   <= rom_cnt_next;
            out_valid_reg <= out_valid_next;

            dist_tag_reg.valid <= (state_reg == ST_RUN) && issue_act_reg;
            dist_tag_reg.last  <= issue_last;
            dist_tag_reg.idx   <= issue_cnt_reg;

            rd_tag_reg   <= w_tag;
            prod_tag_reg <= rd_tag_reg;
            acc_done_reg <= prod_tag_reg.valid && prod_tag_reg.last;

            if (state_reg == ST_DIV)
            begin
                mcnt_reg <= mcnt_reg + MCNT_W'(1);
            end
            else
            begin
                mcnt_reg <= '0;
            end
        end
    end

    // sensor store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (load_xfer && (int'(req.data.sensor_index) < NUM_SENSORS))
        begin
            sv_mem[CNT_W'(req.data.sensor_index)] <= req.data.sensor_value;
        end
        if (w_tag.valid)
        begin
            sv_rd_reg <= sv_mem[w_tag.idx];
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            row_reg <= req.data.grid_row;
            col_reg <= req.data.grid_col;
        end

        ax_reg <= dx_abs[AX_W-1:0];
        ay_reg <= dy_abs[AX_W-1:0];

        rd_w_reg <= weight;

        prod_reg   <= sv_rd_reg * rd_w_reg;
        prod_w_reg <= rd_w_reg;

        if (pix_xfer)
        begin
            sum_reg <= '0;
            tot_reg <= '0;
        end
        else if (prod_tag_reg.valid)
        begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
            tot_reg <= tot_reg + TOT_W'(prod_w_reg);
        end

        // weights are never zero, so tot is never zero
        if (state_reg == ST_RUN && acc_done_reg)
        begin
            qrem_reg <= sum_reg[SUM_W-1:VAL_W];
            qlow_reg <= sum_reg[VAL_W-1:0];
        end
        else if (state_reg == ST_DIV)
        begin
            qrem_reg <= q_ge ? TOT_W'(q_t - {1'b0, tot_reg}) : TOT_W'(q_t);
            qlow_reg <= {qlow_reg[VAL_W-2:0], q_ge};
        end

        if (state_reg == ST_SCALE)
        begin
            scl_reg <= qlow_reg * SCALE_Q16;
        end

        if (out_load)
        begin
            out_data_reg.pixel   <= PIX_W'(PIX_MAX) - scl_sat;
            out_data_reg.out_row <= row_reg;
            out_data_reg.out_col <= col_reg;
        end
    end

    idw_hm_weight u_weight
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (dist_tag_reg),
        .ax      (ax_reg),
        .ay      (ay_reg),
        .out_tag (w_tag),
        .weight  (weight)
    );

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

>>> rtl/idw_hm_checker.sv
// ----------------------------------------------------------------------------
// idw heat map port checker
// port-level assertions, bound to the pixel unit
// ----------------------------------------------------------------------------
`include "idw_heat_map_pixel_unit_macros.svh"

module idw_hm_checker
    import idw_hm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input cmd_t      req_cmd,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_item_t rsp_data
);

    // a stalled result stays offered
    `IDW_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

    // a stalled result keeps its payload
    `IDW_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp changed")

    // a pixel request makes the unit busy
    `IDW_ASSERT_NEXT(a_pix_busy, clk, rst_n, req_valid && req_ready && (req_cmd == CMD_PIXEL), !req_ready, "pixel not busy")

    // a load never blocks the request side
    `IDW_ASSERT_NEXT(a_load_free, clk, rst_n, req_valid && req_ready && (req_cmd == CMD_LOAD), req_ready, "load blocked")

endmodule

bind idw_heat_map_pixel_unit idw_hm_checker u_idw_hm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.data.cmd),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

>>> bench/idw_heat_map_pixel_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idw heat map pixel unit testbench
// loads sensor values, then requests pixels; a local inverse distance
// weighting model predicts each grey level and a monitor compares every
// returned pixel with the oldest prediction under random stalls on both sides
// ----------------------------------------------------------------------------
module idw_heat_map_pixel_unit_test;
    import idw_hm_pkg::*;

    logic clk;
    logic rst_n;

    idw_hm_in_if  req ();
    idw_hm_out_if rsp ();

    idw_heat_map_pixel_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // items waiting to be driven and pixels waiting to come back
    in_item_t  send_queue  [$];
    out_item_t pixel_queue [$];

    // local copy of the sensor store
    logic [VAL_W-1:0] sensor_store [NUM_SENSORS];

    int  error_count;
    int  pixels_seen;
    int  loads_sent;
    bit  calm;          // no idling on either side while set
    int  send_gap;
    int  recv_stall;

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // grey level model
    // ------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [PIX_W-1:0] grey_level(input logic [COORD_W-1:0] row,
                                                     input logic [COORD_W-1:0] col);
        longint          cx;
        longint          cy;
        longint          ex;
        longint          ey;
        longint unsigned dlen;
        longint unsigned wgt;
        longint unsigned wsum;
        longint unsigned wtot;
        longint unsigned mean;
        longint unsigned scaled;
        cx   = (longint'(row) - GRID_HALF) * 256;
        cy   = (longint'(col) - GRID_HALF) * 256;
        wsum = 0;
        wtot = 0;
        for (int k = 0; k < NUM_SENSORS; k++)
        begin
            ex = cx - longint'(POS_X[k % ROM_SIZE]);
            ey = cy - longint'(POS_Y[k % ROM_SIZE]);
            if (ex < 0) ex = -ex;
            if (ey < 0) ey = -ey;
            dlen = int_sqrt(ex * ex + ey * ey);
            // zero distance pins the weight at its ceiling
            if (dlen == 0)
                wgt = 64'hFFFF_FFFF;
            else
                wgt = (64'd1 << 32) / dlen;
            if (wgt > 64'hFFFF_FFFF)
                wgt = 64'hFFFF_FFFF;
            wsum += longint'(sensor_store[k]) * wgt;
            wtot += wgt;
        end
        // zero total cannot happen, but keep the undivided fallback
        mean = (wtot != 0) ? wsum / wtot : (wsum >> 24);
        if (mean > 64'hFF_FFFF)
            mean = 64'hFF_FFFF;
        scaled = (mean * 64'(SCALE_Q16)) >> 24;
        if (scaled > PIX_MAX)
            scaled = PIX_MAX;
        return PIX_W'(PIX_MAX - scaled);
    endfunction

    // a load updates the store; a pixel request queues its prediction
    task automatic apply_request(input in_item_t it);
        out_item_t exp_pix;
        if (it.cmd == CMD_LOAD)
        begin
            if (it.sensor_index < NUM_SENSORS)
                sensor_store[it.sensor_index] = it.sensor_value;
        end
        else
        begin
            exp_pix.pixel   = grey_level(it.grid_row, it.grid_col);
            exp_pix.out_row = it.grid_row;
            exp_pix.out_col = it.grid_col;
            pixel_queue.push_back(exp_pix);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: one transfer per accepted item, random gap after each
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.data  <= '0;
            send_gap  = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                apply_request(req.data);
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req.valid <= 1'b0;
                end
                else if (send_queue.size() > 0)
                begin
                    req.data  <= send_queue.pop_front();
                    req.valid <= 1'b1;
                    send_gap  = calm ? 0 : $urandom_range(0, 11);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back pressure, compare each transfer in order
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                pixels_seen++;
                if (pixel_queue.size() == 0)
                begin
                    $error("pixel transfer with nothing expected");
                    error_count++;
                end
                else
                begin
                    out_item_t want;
                    want = pixel_queue.pop_front();
                    if (rsp.data.pixel !== want.pixel)
                    begin
                        $error("pixel: expected %0d, got %0d", want.pixel, rsp.data.pixel);
                        error_count++;
                    end
                    if (rsp.data.out_row !== want.out_row)
                    begin
                        $error("out_row: expected %0d, got %0d",
                               want.out_row, rsp.data.out_row);
                        error_count++;
                    end
                    if (rsp.data.out_col !== want.out_col)
                    begin
                        $error("out_col: expected %0d, got %0d",
                               want.out_col, rsp.data.out_col);
                        error_count++;
                    end
                end
                recv_stall = calm ? 0 : $urandom_range(0, 11);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic in_item_t load_item(input int idx, input int val);
        in_item_t it;
        it              = '0;
        it.cmd          = CMD_LOAD;
        it.sensor_index = IDX_W'(idx);
        it.sensor_value = VAL_W'(val);
        it.grid_row     = COORD_W'($urandom);
        it.grid_col     = COORD_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t pixel_item(input int row, input int col);
        in_item_t it;
        it              = '0;
        it.cmd          = CMD_PIXEL;
        it.sensor_index = IDX_W'($urandom);
        it.sensor_value = VAL_W'($urandom);
        it.grid_row     = COORD_W'(row);
        it.grid_col     = COORD_W'(col);
        return it;
    endfunction

    task automatic drain_requests();
        while (send_queue.size() > 0 || req.valid)
            @(posedge clk);
    endtask

    initial
    begin
        error_count = 0;
        pixels_seen = 0;
        loads_sent  = 0;
        calm        = 1'b0;
        for (int k = 0; k < NUM_SENSORS; k++)
            sensor_store[k] = '0;

        // every sensor is written before the first pixel is asked for
        for (int k = 0; k < NUM_SENSORS; k++)
            send_queue.push_back(load_item(k, (k % 3 == 0) ? 16'hFFFF : $urandom));

        // directed: grid corners, center, beyond-grid coordinates, ignored loads
        send_queue.push_back(pixel_item(0, 0));
        send_queue.push_back(pixel_item(199, 199));
        send_queue.push_back(pixel_item(0, 199));
        send_queue.push_back(pixel_item(199, 0));
        send_queue.push_back(pixel_item(100, 100));
        send_queue.push_back(pixel_item(255, 255));
        send_queue.push_back(pixel_item(200, 0));
        send_queue.push_back(load_item(54, 16'h1234));
        send_queue.push_back(load_item(63, 16'hFFFF));
        send_queue.push_back(pixel_item(100, 100));
        // all sensors at full scale saturates the scaled mean
        for (int k = 0; k < NUM_SENSORS; k++)
            send_queue.push_back(load_item(k, 16'hFFFF));
        send_queue.push_back(pixel_item(100, 100));
        // all zero gives white
        for (int k = 0; k < NUM_SENSORS; k++)
            send_queue.push_back(load_item(k, 0));
        send_queue.push_back(pixel_item(50, 150));
        send_queue.push_back(load_item(0, 16'h0100));
        send_queue.push_back(pixel_item(69, 20));

        // sender holds off until every pixel is back
        wait (rst_n);
        drain_requests();
        while (pixel_queue.size() > 0)
            @(posedge clk);

        // random part, with two calm stretches
        for (int n = 0; n < 1550; n++)
        begin
            if (n % 100 == 0)
            begin
                drain_requests();
                calm = (n == 600 || n == 1200);
            end
            if ($urandom_range(0, 9) < 3)
            begin
                loads_sent++;
                if ($urandom_range(0, 7) == 0)
                    send_queue.push_back(load_item($urandom_range(0, 63), $urandom));
                else
                    send_queue.push_back(load_item($urandom_range(0, NUM_SENSORS - 1),
                                                   ($urandom_range(0, 5) == 0) ?
                                                   16'hFFFF : $urandom_range(0, 2047)));
            end
            else if ($urandom_range(0, 9) == 0)
                send_queue.push_back(pixel_item($urandom_range(0, 255),
                                                $urandom_range(0, 255)));
            else
                send_queue.push_back(pixel_item($urandom_range(0, GRID_DIM - 1),
                                                $urandom_range(0, GRID_DIM - 1)));
        end

        drain_requests();
        while (pixel_queue.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("run covered %0d returned pixels and %0d random sensor loads,",
                 pixels_seen, loads_sent);
        $display("grid corners, beyond-grid points and ignored sensor indexes");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> idw_heat_map_pixel_unit.f
+incdir+rtl
rtl/idw_hm_pkg.sv
rtl/idw_hm_in_if.sv
rtl/idw_hm_out_if.sv
rtl/idw_hm_weight.sv
rtl/idw_heat_map_pixel_unit.sv
rtl/idw_hm_checker.sv
bench/idw_heat_map_pixel_unit_test.sv
